/* rtl/jhsh_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash package
// Shared constants, the parser phase type and the word that the front end
// hands to the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package jhsh_pkg;

    // FNV-1a constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Marker byte codes.
    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_DRI  = 8'hDD;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;
    localparam logic [7:0] MK_STUF = 8'h00;
    localparam logic [7:0] MK_TEM  = 8'h01;

    // Depth of the queue between the parser and the hash engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Parser phase.
    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_SCAN,
        PH_FILL,
        PH_LENHI,
        PH_LENLO,
        PH_PAYLOAD,
        PH_STOP,
        PH_REJECT
    } phase_t;

    // One word of work for the hash engine.
    typedef struct packed {
        logic [7:0]  data;      // byte to fold
        logic        fold;      // fold data into the segment hash
        logic        start;     // first fold of a segment starts from committed hash
        logic        commit;    // segment complete: committed hash takes segment hash
        logic        emit;      // frame end: deliver a result
        logic        zero;      // result is zero (not a JPEG or short frame)
        logic [15:0] restart;   // restart interval to deliver with the result
    } hash_op_t;

endpackage

`default_nettype wire

/* rtl/jhsh_front.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash: parser front end
// Walks the marker segments one byte per cycle while bytes are accepted, tracks segment lengths and the
// restart interval, and sends one hash word per byte that matters.
// ----------------------------------------------------------------------------
`default_nettype none

module jhsh_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    accept,
    input  wire  [7:0]             data_byte,
    input  wire                    last_byte,
    output logic                   op_push,
    output jhsh_pkg::hash_op_t     op
);

    jhsh_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  byte_count_reg, byte_count_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] restart_reg, restart_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [2:0]  offset_reg, offset_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  lenhi_reg, lenhi_next;

    logic        is_standalone;
    logic [15:0] seglen;
    logic [15:0] seglen_rem;
    logic [15:0] rem_dec;
    logic [15:0] pending_upd;
    logic [2:0]  offset_inc;
    logic        restart_take;
    logic [15:0] restart_after;

    // Decode of the current byte against the parser state.
    always_comb
    begin
        is_standalone = (data_byte inside {jhsh_pkg::MK_STUF, jhsh_pkg::MK_TEM,
                         [jhsh_pkg::MK_RST0:jhsh_pkg::MK_RST7]});
        seglen     = {lenhi_reg, data_byte};
        seglen_rem = seglen - 16'd2;
        rem_dec    = remaining_reg - 16'd1;
        if (offset_reg == 3'd2)
        begin
            pending_upd = {data_byte, 8'h00};
        end
        else if (offset_reg == 3'd3)
        begin
            pending_upd = pending_reg | {8'h00, data_byte};
        end
        else
        begin
            pending_upd = pending_reg;
        end
        offset_inc   = (offset_reg < 3'd4) ? offset_reg + 3'd1 : offset_reg;
        restart_take = (phase_reg == jhsh_pkg::PH_PAYLOAD) && (rem_dec == 16'd0) &&
                       (marker_reg == jhsh_pkg::MK_DRI) && (offset_inc >= 3'd4);
        restart_after = restart_take ? pending_upd : restart_reg;
    end

    // Next state of the parser.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        pending_next    = pending_reg;
        restart_next    = restart_reg;
        remaining_next  = remaining_reg;
        offset_next     = offset_reg;
        marker_next     = marker_reg;
        lenhi_next      = lenhi_reg;
        if (accept)
        begin
            case (phase_reg)
                jhsh_pkg::PH_SOI0:
                begin
                    phase_next = (data_byte == jhsh_pkg::MK_FILL) ?
                                 jhsh_pkg::PH_SOI1 : jhsh_pkg::PH_REJECT;
                end
                jhsh_pkg::PH_SOI1:
                begin
                    phase_next = (data_byte == jhsh_pkg::MK_SOI) ?
                                 jhsh_pkg::PH_SCAN : jhsh_pkg::PH_REJECT;
                end
                jhsh_pkg::PH_SCAN:
                begin
                    if (data_byte == jhsh_pkg::MK_FILL)
                    begin
                        phase_next = jhsh_pkg::PH_FILL;
                    end
                end
                jhsh_pkg::PH_FILL:
                begin
                    if (data_byte == jhsh_pkg::MK_FILL)
                    begin
                        phase_next = jhsh_pkg::PH_FILL;
                    end
                    else if (data_byte == jhsh_pkg::MK_SOS || data_byte == jhsh_pkg::MK_EOI)
                    begin
                        phase_next = jhsh_pkg::PH_STOP;
                    end
                    else if (is_standalone)
                    begin
                        phase_next = jhsh_pkg::PH_SCAN;
                    end
                    else
                    begin
                        marker_next  = data_byte;
                        offset_next  = 3'd0;
                        pending_next = 16'd0;
                        phase_next   = jhsh_pkg::PH_LENHI;
                    end
                end
                jhsh_pkg::PH_LENHI:
                begin
                    lenhi_next  = data_byte;
                    offset_next = 3'd1;
                    phase_next  = jhsh_pkg::PH_LENLO;
                end
                jhsh_pkg::PH_LENLO:
                begin
                    offset_next = 3'd2;
                    if (seglen < 16'd2)
                    begin
                        phase_next = jhsh_pkg::PH_STOP;
                    end
                    else
                    begin
                        remaining_next = seglen_rem;
                        phase_next = (seglen_rem == 16'd0) ?
                                     jhsh_pkg::PH_SCAN : jhsh_pkg::PH_PAYLOAD;
                    end
                end
                jhsh_pkg::PH_PAYLOAD:
                begin
                    pending_next   = pending_upd;
                    offset_next    = offset_inc;
                    remaining_next = rem_dec;
                    restart_next   = restart_after;
                    if (rem_dec == 16'd0)
                    begin
                        phase_next = jhsh_pkg::PH_SCAN;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // The frame end returns the parser to its reset state.
            if (last_byte)
            begin
                phase_next      = jhsh_pkg::PH_SOI0;
                byte_count_next = 2'd0;
                pending_next    = 16'd0;
                restart_next    = 16'd0;
                remaining_next  = 16'd0;
                offset_next     = 3'd0;
                marker_next     = 8'h00;
                lenhi_next      = 8'h00;
            end
            else if (byte_count_reg != 2'd3)
            begin
                byte_count_next = byte_count_reg + 2'd1;
            end
        end
    end

    // Hash word for the engine.
    always_comb
    begin
        op.data    = data_byte;
        op.fold    = 1'b0;
        op.start   = 1'b0;
        op.commit  = 1'b0;
        op.emit    = last_byte;
        op.zero    = 1'b0;
        op.restart = 16'd0;
        case (phase_reg)
            jhsh_pkg::PH_SOI0:
            begin
                op.zero = (data_byte != jhsh_pkg::MK_FILL);
            end
            jhsh_pkg::PH_SOI1:
            begin
                op.zero = (data_byte != jhsh_pkg::MK_SOI);
            end
            jhsh_pkg::PH_FILL:
            begin
                if (data_byte != jhsh_pkg::MK_FILL && data_byte != jhsh_pkg::MK_SOS &&
                    data_byte != jhsh_pkg::MK_EOI && !is_standalone)
                begin
                    op.fold  = 1'b1;
                    op.start = 1'b1;
                end
            end
            jhsh_pkg::PH_LENHI:
            begin
                op.fold = 1'b1;
            end
            jhsh_pkg::PH_LENLO:
            begin
                op.fold   = 1'b1;
                op.commit = (seglen >= 16'd2) && (seglen_rem == 16'd0);
            end
            jhsh_pkg::PH_PAYLOAD:
            begin
                op.fold   = 1'b1;
                op.commit = (rem_dec == 16'd0);
            end
            jhsh_pkg::PH_REJECT:
            begin
                op.zero = 1'b1;
            end
            default:
            begin
                op.zero = 1'b0;
            end
        endcase
        if (byte_count_reg != 2'd3)
        begin
            op.zero = 1'b1;
        end
        if (!op.zero)
        begin
            op.restart = restart_after;
        end
        op_push = accept && (op.fold || op.commit || op.emit);
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= jhsh_pkg::PH_SOI0;
            byte_count_reg <= 2'd0;
            pending_reg    <= 16'd0;
            restart_reg    <= 16'd0;
            remaining_reg  <= 16'd0;
            offset_reg     <= 3'd0;
            marker_reg     <= 8'h00;
            lenhi_reg      <= 8'h00;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            pending_reg    <= pending_next;
            restart_reg    <= restart_next;
            remaining_reg  <= remaining_next;
            offset_reg     <= offset_next;
            marker_reg     <= marker_next;
            lenhi_reg      <= lenhi_next;
        end
    end

    // The frame end always leaves the parser waiting for a new SOI.
    a_frame_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == jhsh_pkg::PH_SOI0 && byte_count_reg == 2'd0)
        else $error("parser not back at frame start after last byte");

    // Payload bytes are only counted down while some remain.
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == jhsh_pkg::PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with nothing remaining");

endmodule

`default_nettype wire

/* rtl/jhsh_op_queue.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash: word queue
// Short first-in first-out queue of hash words between parser and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module jhsh_op_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire jhsh_pkg::hash_op_t push_op,
    output logic                   full,
    input  wire                    pop,
    output jhsh_pkg::hash_op_t     head_op,
    output logic                   empty
);

    jhsh_pkg::hash_op_t slots [jhsh_pkg::QUEUE_DEPTH];

    logic [jhsh_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jhsh_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jhsh_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    // Status and pointer update.
    always_comb
    begin
        full    = (count_reg == jhsh_pkg::QUEUE_CW'(jhsh_pkg::QUEUE_DEPTH));
        empty   = (count_reg == '0);
        do_push = push && !full;
        do_pop  = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + jhsh_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + jhsh_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + jhsh_pkg::QUEUE_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - jhsh_pkg::QUEUE_CW'(1);
        end
        head_op = slots[rd_ptr_reg];
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count agrees with the pointer distance.
    a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[jhsh_pkg::QUEUE_AW-1:0] == jhsh_pkg::QUEUE_AW'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");

    // A lone push grows the queue by one word.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + jhsh_pkg::QUEUE_CW'(1))
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

/* rtl/jhsh_back.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash: hash engine
// Folds bytes into the FNV-1a segment hash, commits complete segments and
// holds the frame result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jhsh_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    op_valid,
    input  wire jhsh_pkg::hash_op_t op,
    output logic                   op_take,
    input  wire                    pop,
    output logic                   empty,
    output logic [31:0]            frame_hash,
    output logic [15:0]            dri_interval
);

    logic [31:0] seg_reg, seg_next;
    logic [31:0] committed_reg, committed_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic [15:0] out_restart_reg, out_restart_next;

    logic        out_take;
    logic [31:0] fold_base;
    logic [31:0] folded;
    logic [31:0] seg_upd;
    logic [31:0] committed_upd;

    // Word acceptance: a frame-end word waits until the output register frees.
    always_comb
    begin
        out_take = pop && out_valid_reg;
        op_take  = op_valid && !(op.emit && out_valid_reg && !out_take);
    end

    // At most one FNV-1a fold per word.
    always_comb
    begin
        fold_base     = op.start ? committed_reg : seg_reg;
        folded        = (fold_base ^ {24'h000000, op.data}) * jhsh_pkg::FNV_PRIME;
        seg_upd       = op.fold ? folded : seg_reg;
        committed_upd = op.commit ? seg_upd : committed_reg;
    end

    // Next state of the hash and the output register.
    always_comb
    begin
        seg_next         = seg_reg;
        committed_next   = committed_reg;
        out_valid_next   = out_valid_reg && !out_take;
        out_hash_next    = out_hash_reg;
        out_restart_next = out_restart_reg;
        if (op_take)
        begin
            seg_next       = seg_upd;
            committed_next = committed_upd;
            if (op.emit)
            begin
                seg_next         = jhsh_pkg::FNV_BASIS;
                committed_next   = jhsh_pkg::FNV_BASIS;
                out_valid_next   = 1'b1;
                out_hash_next    = op.zero ? 32'd0 : committed_upd;
                out_restart_next = op.restart;
            end
        end
    end

    // Result ports.
    always_comb
    begin
        empty        = !out_valid_reg;
        frame_hash   = out_hash_reg;
        dri_interval = out_restart_reg;
    end

    // Hash registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= jhsh_pkg::FNV_BASIS;
            committed_reg <= jhsh_pkg::FNV_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            committed_reg <= committed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_hash_reg    <= out_hash_next;
        out_restart_reg <= out_restart_next;
    end

    // A frame-end word always leaves a result waiting.
    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        op_take && op.emit |=> out_valid_reg)
        else $error("frame end word did not produce a result");

    // A frame-end word restarts the committed hash.
    a_emit_clears_hash: assert property (@(posedge clk) disable iff (!rst_n)
        op_take && op.emit |=> committed_reg == jhsh_pkg::FNV_BASIS)
        else $error("committed hash not restarted at frame end");

endmodule

`default_nettype wire

/* rtl/jpeg_header_segment_hash.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash
// Parses the marker segments of a JPEG frame and delivers an FNV-1a hash of
// the complete header segments and the DRI restart interval at frame end.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parser takes a byte every cycle while
// the four-word queue has room, and the hash engine does one fold per cycle
// while no frame-end word waits for the result register to free. The parser
// writes the frame-end word into the queue when it takes the last byte, and
// the engine then loads it from the queue head into the result register.
// Reset: asynchronous; the parser waits for SOI, queue and result are empty.
`default_nettype none

module jpeg_header_segment_hash (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  data_byte,
    input  wire         last_byte,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] frame_hash,
    output logic [15:0] dri_interval
);

    jhsh_pkg::hash_op_t front_op;
    jhsh_pkg::hash_op_t head_op;
    logic               accept;
    logic               front_push;
    logic               queue_empty;
    logic               op_take;

    assign accept = push && !full;

    // Parser front end.
    jhsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .op_push   (front_push),
        .op        (front_op)
    );

    // Queue between parser and hash engine.
    jhsh_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .push_op (front_op),
        .full    (full),
        .pop     (op_take),
        .head_op (head_op),
        .empty   (queue_empty)
    );

    // Hash engine and result register.
    jhsh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (!queue_empty),
        .op           (head_op),
        .op_take      (op_take),
        .pop          (pop),
        .empty        (empty),
        .frame_hash   (frame_hash),
        .dri_interval (dri_interval)
    );

endmodule

`default_nettype wire

/* dv/jpeg_header_segment_hash_test.sv */
// ----------------------------------------------------------------------------
// JPEG header segment hash testbench
// Streams JPEG-like frames into the parser one byte word at a time and
// predicts each frame-end result in a behavioral copy of the segment walker.
// A short directed table comes first. Random frames follow, most of them
// well formed with random segment content. Both handshakes idle at random,
// and the result side holds off once so that the input backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module jpeg_header_segment_hash_test;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 1650;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 300;
    localparam int QUIET_FROM    = 1000;
    localparam int QUIET_TO      = 1600;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // One planned input word; typed rows carry their expected result.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [31:0] hash;
        logic [15:0] restart;
    } plan_row_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [15:0] restart;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [31:0] frame_hash;
    logic [15:0] dri_interval;
    logic        hold_results = 1'b0;

    plan_row_t     byte_plan[$];
    frame_result_t results_due[$];

    int cycle_no       = 0;
    int bytes_taken    = 0;
    int frames_checked = 0;
    int restart_frames = 0;
    int zero_frames    = 0;
    int stall_cycles   = 0;
    int mismatch_count = 0;

    // Behavioral copy of the segment walker.
    jhsh_pkg::phase_t walk_phase;
    logic [1:0]  bytes_seen;
    logic [31:0] hash_done;
    logic [31:0] hash_open;
    logic [15:0] restart_done;
    logic [15:0] restart_open;
    logic [15:0] payload_left;
    logic [2:0]  seg_pos;
    logic [7:0]  cur_marker;
    logic [7:0]  len_hi;

    // Directed frames: rejected, short, bare SOI and EOI, and a full DRI walk.
    plan_row_t directed_rows [DIRECTED_ROWS] = '{
        // First byte is not FF.
        '{8'h00, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_SOI, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'hC0, 1'b1, 1'b1, 32'h0, 16'h0},
        // Second byte is not SOI.
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'h11, 1'b1, 1'b1, 32'h0, 16'h0},
        // Two-byte frame is too short.
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_SOI, 1'b1, 1'b1, 32'h0, 16'h0},
        // SOI followed directly by EOI: no segment, hash stays at the basis.
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_SOI, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_EOI, 1'b1, 1'b1, jhsh_pkg::FNV_BASIS, 16'h0},
        // Fill run, a restart marker, then DRI with the largest interval.
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_SOI, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_RST0, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_FILL, 1'b0, 1'b0, 32'h0, 16'h0},
        '{jhsh_pkg::MK_DRI, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'h04, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0, 16'h0},
        '{8'h00, 1'b1, 1'b0, 32'h0, 16'h0}
    };

    jpeg_header_segment_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .frame_hash   (frame_hash),
        .dri_interval (dri_interval)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // Random idle decision, switched off inside the quiet window.
    function automatic bit take_break();
        if (cycle_no >= QUIET_FROM && cycle_no < QUIET_TO)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 19;
    endfunction

    function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * jhsh_pkg::FNV_PRIME;
    endfunction

    task automatic clear_walk();
        walk_phase   = jhsh_pkg::PH_SOI0;
        bytes_seen   = '0;
        hash_done    = jhsh_pkg::FNV_BASIS;
        hash_open    = jhsh_pkg::FNV_BASIS;
        restart_done = '0;
        restart_open = '0;
        payload_left = '0;
        seg_pos      = '0;
        cur_marker   = '0;
        len_hi       = '0;
    endtask

    // A complete segment becomes part of the frame hash; a DRI with both
    // interval bytes present also updates the restart interval.
    task automatic close_segment();
        hash_done = hash_open;
        if (cur_marker == jhsh_pkg::MK_DRI && seg_pos >= 3'd4)
        begin
            restart_done = restart_open;
        end
        walk_phase = jhsh_pkg::PH_SCAN;
    endtask

    // Advance the walker by one byte word and report a frame-end result.
    task automatic walk_byte(input logic [7:0] b, input logic last_b, output bit produced,
                             output logic [31:0] h_out, output logic [15:0] r_out);
        logic [15:0] seg_len;
        produced = 1'b0;
        h_out    = '0;
        r_out    = '0;
        case (walk_phase)
            jhsh_pkg::PH_SOI0:
            begin
                walk_phase = (b == jhsh_pkg::MK_FILL) ? jhsh_pkg::PH_SOI1 : jhsh_pkg::PH_REJECT;
            end
            jhsh_pkg::PH_SOI1:
            begin
                walk_phase = (b == jhsh_pkg::MK_SOI) ? jhsh_pkg::PH_SCAN : jhsh_pkg::PH_REJECT;
            end
            jhsh_pkg::PH_SCAN:
            begin
                if (b == jhsh_pkg::MK_FILL)
                begin
                    walk_phase = jhsh_pkg::PH_FILL;
                end
            end
            jhsh_pkg::PH_FILL:
            begin
                if (b == jhsh_pkg::MK_FILL)
                begin
                    walk_phase = jhsh_pkg::PH_FILL;
                end
                else if (b == jhsh_pkg::MK_SOS || b == jhsh_pkg::MK_EOI)
                begin
                    walk_phase = jhsh_pkg::PH_STOP;
                end
                else if (b == jhsh_pkg::MK_STUF || b == jhsh_pkg::MK_TEM ||
                         (b >= jhsh_pkg::MK_RST0 && b <= jhsh_pkg::MK_RST7))
                begin
                    walk_phase = jhsh_pkg::PH_SCAN;
                end
                else
                begin
                    cur_marker   = b;
                    hash_open    = fnv_fold(hash_done, b);
                    seg_pos      = 3'd0;
                    restart_open = '0;
                    walk_phase   = jhsh_pkg::PH_LENHI;
                end
            end
            jhsh_pkg::PH_LENHI:
            begin
                len_hi     = b;
                hash_open  = fnv_fold(hash_open, b);
                seg_pos    = 3'd1;
                walk_phase = jhsh_pkg::PH_LENLO;
            end
            jhsh_pkg::PH_LENLO:
            begin
                seg_len   = {len_hi, b};
                hash_open = fnv_fold(hash_open, b);
                seg_pos   = 3'd2;
                if (seg_len < 16'd2)
                begin
                    walk_phase = jhsh_pkg::PH_STOP;
                end
                else
                begin
                    payload_left = seg_len - 16'd2;
                    if (payload_left == 16'd0)
                    begin
                        close_segment();
                    end
                    else
                    begin
                        walk_phase = jhsh_pkg::PH_PAYLOAD;
                    end
                end
            end
            jhsh_pkg::PH_PAYLOAD:
            begin
                hash_open = fnv_fold(hash_open, b);
                if (seg_pos == 3'd2)
                begin
                    restart_open = {b, 8'h00};
                end
                else if (seg_pos == 3'd3)
                begin
                    restart_open = restart_open | {8'h00, b};
                end
                if (seg_pos < 3'd4)
                begin
                    seg_pos = seg_pos + 3'd1;
                end
                payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                begin
                    close_segment();
                end
            end
            default:
            begin
            end
        endcase

        if (!last_b)
        begin
            if (bytes_seen < 2'd3)
            begin
                bytes_seen = bytes_seen + 2'd1;
            end
        end
        else
        begin
            produced = 1'b1;
            if (walk_phase != jhsh_pkg::PH_REJECT && bytes_seen == 2'd3)
            begin
                h_out = hash_done;
                r_out = restart_done;
            end
            clear_walk();
        end
    endtask

    // Build one random frame: mostly a well-formed segment walk with random
    // content, sometimes noise or a broken SOI.
    task automatic plan_random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  mk;
        logic [15:0] len;
        int          kind;
        int          seg_kind;
        int          segs;
        int          n;
        bit          done;
        plan_row_t   row;
        kind = $urandom_range(0, 99);
        done = 1'b0;
        if (kind < 7)
        begin
            n = $urandom_range(1, 6);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 11)
        begin
            fb.push_back($urandom_range(0, 1) ? jhsh_pkg::MK_FILL : 8'($urandom_range(0, 255)));
            fb.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 8);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            fb.push_back(jhsh_pkg::MK_FILL);
            fb.push_back(jhsh_pkg::MK_SOI);
            segs = $urandom_range(1, 5);
            for (int s = 0; s < segs && !done; s++)
            begin
                seg_kind = $urandom_range(0, 99);
                // Stray bytes between segments, then the marker prefix.
                if ($urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) fb.push_back(8'($urandom_range(0, 254)));
                end
                fb.push_back(jhsh_pkg::MK_FILL);
                if ($urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) fb.push_back(jhsh_pkg::MK_FILL);
                end
                do
                begin
                    mk = 8'($urandom_range(2, 254));
                end
                while ((mk >= jhsh_pkg::MK_RST0 && mk <= jhsh_pkg::MK_RST7) ||
                       mk == jhsh_pkg::MK_SOS || mk == jhsh_pkg::MK_EOI ||
                       mk == jhsh_pkg::MK_DRI);
                if (seg_kind < 10)
                begin
                    case ($urandom_range(0, 2))
                        0: fb.push_back(jhsh_pkg::MK_STUF);
                        1: fb.push_back(jhsh_pkg::MK_TEM);
                        default: fb.push_back(jhsh_pkg::MK_RST0 + 8'($urandom_range(0, 7)));
                    endcase
                end
                else if (seg_kind < 20)
                begin
                    // SOS, EOI or a length below two ends the walk.
                    if (seg_kind < 16)
                    begin
                        fb.push_back($urandom_range(0, 1) ? jhsh_pkg::MK_SOS :
                                                            jhsh_pkg::MK_EOI);
                    end
                    else
                    begin
                        fb.push_back(mk);
                        fb.push_back(8'h00);
                        fb.push_back(8'($urandom_range(0, 1)));
                    end
                    n = $urandom_range(0, 6);
                    repeat (n) fb.push_back(8'($urandom_range(0, 255)));
                    done = 1'b1;
                end
                else
                begin
                    if (seg_kind < 40)
                    begin
                        mk  = jhsh_pkg::MK_DRI;
                        len = 16'($urandom_range(2, 7));
                    end
                    else if (seg_kind >= 95)
                    begin
                        len = 16'($urandom_range(256, 65535));
                    end
                    else
                    begin
                        len = 16'($urandom_range(2, 12));
                    end
                    fb.push_back(mk);
                    fb.push_back(len[15:8]);
                    fb.push_back(len[7:0]);
                    n = int'(len) - 2;
                    // Cut the segment off with the frame end now and then.
                    if (seg_kind >= 95 || $urandom_range(0, 7) == 0)
                    begin
                        n    = $urandom_range(0, (n > 10) ? 10 : n);
                        done = 1'b1;
                    end
                    repeat (n) fb.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (!done)
            begin
                fb.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (fb[i])
        begin
            row       = '0;
            row.data  = fb[i];
            row.last  = (i == fb.size() - 1);
            byte_plan.push_back(row);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] result %0d %s: expected %h, got %h", $realtime, frames_checked,
                     what, want, got);
        end
    endtask

    // Reset, stimulus plan and the input side.
    initial
    begin : drive_bytes
        int pos;
        int frames_due;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        clear_walk();
        foreach (directed_rows[i])
        begin
            byte_plan.push_back(directed_rows[i]);
        end
        while (byte_plan.size() < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            plan_random_frame();
        end
        frames_due = 0;
        foreach (byte_plan[i])
        begin
            if (byte_plan[i].last)
            begin
                frames_due++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        pos = 0;
        while (pos < byte_plan.size())
        begin
            @(posedge clk);
            if (push && !full)
            begin
                pos++;
            end
            if (pos < byte_plan.size() && !take_break())
            begin
                push      <= 1'b1;
                data_byte <= byte_plan[pos].data;
                last_byte <= byte_plan[pos].last;
            end
            else
            begin
                push <= 1'b0;
            end
        end

        // Wait for every frame result, then let stragglers drain.
        while (frames_checked < frames_due)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d frame results over %0d byte words: %0d with a restart interval,",
                 frames_checked, bytes_taken, restart_frames);
        $display("%0d zero (rejected or short); input held off by full for %0d cycles.",
                 zero_frames, stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random pops, suspended during the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= !hold_results && !take_break();
        end
    end

    // Long hold-off on the result side while bytes keep arriving.
    initial
    begin : hold_off
        @(posedge rst_n);
        while (bytes_taken < HOLD_AFTER)
        begin
            @(posedge clk);
        end
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Predict on every accepted input word, check every accepted result word.
    always @(posedge clk)
    begin : watch_ports
        bit            produced;
        logic [31:0]   h;
        logic [15:0]   r;
        frame_result_t want;
        frame_result_t due;
        if (rst_n)
        begin
            if (push && !full)
            begin
                walk_byte(data_byte, last_byte, produced, h, r);
                if (produced)
                begin
                    if (byte_plan[bytes_taken].typed)
                    begin
                        h = byte_plan[bytes_taken].hash;
                        r = byte_plan[bytes_taken].restart;
                    end
                    due.hash    = h;
                    due.restart = r;
                    results_due.push_back(due);
                end
                bytes_taken++;
            end
            if (push && full)
            begin
                stall_cycles++;
            end
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    note_mismatch("unexpected result, hash", 32'h0, frame_hash);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (frame_hash !== want.hash)
                    begin
                        note_mismatch("frame_hash", want.hash, frame_hash);
                    end
                    if (dri_interval !== want.restart)
                    begin
                        note_mismatch("dri_interval", {16'd0, want.restart},
                                      {16'd0, dri_interval});
                    end
                    if (want.restart != 16'd0)
                    begin
                        restart_frames++;
                    end
                    if (want.hash == 32'd0)
                    begin
                        zero_frames++;
                    end
                end
                frames_checked++;
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin : run_limit
        #500_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/jhsh_pkg.sv
rtl/jhsh_front.sv
rtl/jhsh_op_queue.sv
rtl/jhsh_back.sv
rtl/jpeg_header_segment_hash.sv
dv/jpeg_header_segment_hash_test.sv
